/* rtl/sfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants for the sensor frame checker
// Frame byte positions, CRC-8 helper, conversion constants and the frame
// record passed from the front end to the conversion back end.
// ----------------------------------------------------------------------------
package sfc_pkg;

   // frame byte positions
   localparam int POS_W = 3;
   localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
   localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
   localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
   localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
   localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
   localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

   // crc-8, polynomial 0x31, seed 0xff, msb first, no final xor
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // conversion constants (q8 results)
   localparam int WORD_W  = 16;
   localparam int TEMP_W  = 17;
   localparam int HUM_W   = 15;
   localparam int TPROD_W = 24;
   localparam int HPROD_W = 23;
   localparam logic [7:0]        TEMP_SCALE  = 8'd175;
   localparam logic [7:0]        HUM_SCALE   = 8'd100;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 17'd11520;

   // frame queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // one checked frame handed to the back end
   typedef struct packed {
      logic [WORD_W-1:0] temp_word;
      logic [WORD_W-1:0] hum_word;
      logic              crc_bad;
   } frame_rec_type;

   // one byte through the crc
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/sfc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_front: frame byte parser and crc checker
// Tracks the byte position, runs the crc over each word, assembles the two
// words and pushes one frame record on the last byte.
// ----------------------------------------------------------------------------
module sfc_front
   import sfc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          byte_valid,
   input  wire logic [7:0]    byte_data,
   input  wire logic          byte_first,
   output frame_rec_type      rec_data,
   output logic               rec_push
);

   logic [POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [7:0]        crc_ff, crc_in;
   logic [WORD_W-1:0] temp_ff, temp_in;
   logic [WORD_W-1:0] hum_ff, hum_in;
   logic              tbad_ff, tbad_in;
   logic [7:0]        crc_next;

   // effective position: a frame start or an unused code restarts the frame
   assign pos_eff  = (byte_first || (pos_ff > POS_H_CRC)) ? POS_T_HI : pos_ff;
   assign crc_next = crc8_update((pos_eff == POS_T_HI || pos_eff == POS_H_HI) ?
                                 CRC_INIT : crc_ff, byte_data);

   // per-position update
   always_comb begin
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      temp_in  = temp_ff;
      hum_in   = hum_ff;
      tbad_in  = tbad_ff;
      rec_push = 1'b0;
      rec_data.temp_word = temp_ff;
      rec_data.hum_word  = hum_ff;
      rec_data.crc_bad   = tbad_ff || (crc_ff != byte_data);
      if (byte_valid) begin
         pos_in = pos_eff + 3'd1;
         case (pos_eff)
            POS_T_HI: begin
               crc_in  = crc_next;
               temp_in = {byte_data, 8'h00};
            end
            POS_T_LO: begin
               crc_in  = crc_next;
               temp_in = {temp_ff[15:8], byte_data};
            end
            POS_T_CRC: begin
               tbad_in = (crc_ff != byte_data);
               crc_in  = CRC_INIT;
            end
            POS_H_HI: begin
               crc_in = crc_next;
               hum_in = {byte_data, 8'h00};
            end
            POS_H_LO: begin
               crc_in = crc_next;
               hum_in = {hum_ff[15:8], byte_data};
            end
            default: begin
               crc_in   = CRC_INIT;
               pos_in   = POS_T_HI;
               rec_push = 1'b1;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_T_HI;
         crc_ff  <= CRC_INIT;
         temp_ff <= '0;
         hum_ff  <= '0;
         tbad_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         temp_ff <= temp_in;
         hum_ff  <= hum_in;
         tbad_ff <= tbad_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/sfc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_queue: two-entry frame record queue
// Decouples the byte front end from the conversion back end.
// ----------------------------------------------------------------------------
module sfc_queue
   import sfc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire frame_rec_type push_data,
   output logic               not_full,
   input  wire logic          pop,
   output frame_rec_type      pop_data,
   output logic               not_empty
);

   frame_rec_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign not_full  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("frame record pushed into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fill count did not follow push");
`endif

endmodule
`default_nettype wire

/* rtl/sfc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_back: frame conversion back end
// Scales the two words to q8 units in a multiply stage and an output
// register stage, zeroing both values on a crc failure.
// ----------------------------------------------------------------------------
module sfc_back
   import sfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rec_valid,
   input  wire frame_rec_type     rec_data,
   output logic                   rec_pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [TEMP_W-1:0]      out_temp,
   output logic [HUM_W-1:0]       out_hum,
   output logic                   out_bad
);

   logic               s1_valid_ff, s2_valid_ff;
   logic [TPROD_W-1:0] tprod_ff;
   logic [HPROD_W-1:0] hprod_ff;
   logic               s1_bad_ff;
   logic [TEMP_W-1:0]  temp_ff, temp_in;
   logic [HUM_W-1:0]   hum_ff, hum_in;
   logic               bad_ff;
   logic               s1_ready, s2_ready;

   // stage handshakes
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign rec_pop  = rec_valid && s1_ready;

   // final scaling and offset, zero on error
   always_comb begin
      if (s1_bad_ff) begin
         temp_in = '0;
         hum_in  = '0;
      end else begin
         temp_in = {1'b0, tprod_ff[TPROD_W-1:8]} - TEMP_OFFSET;
         hum_in  = hprod_ff[HPROD_W-1:8];
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= rec_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (rec_pop) begin
         tprod_ff  <= TPROD_W'(rec_data.temp_word) * TPROD_W'(TEMP_SCALE);
         hprod_ff  <= HPROD_W'(rec_data.hum_word) * HPROD_W'(HUM_SCALE);
         s1_bad_ff <= rec_data.crc_bad;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         temp_ff <= temp_in;
         hum_ff  <= hum_in;
         bad_ff  <= s1_bad_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_temp  = temp_ff;
   assign out_hum   = hum_ff;
   assign out_bad   = bad_ff;

`ifndef SYNTHESIS
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_temp) && $stable(out_bad)))
      else $error("result changed while stalled");
   a_zero_on_bad: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_bad) |-> (out_temp == '0 && out_hum == '0))
      else $error("non-zero values on crc failure");
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      rec_pop |-> (!s1_valid_ff || !s2_valid_ff || out_ready))
      else $error("record popped with no room in pipeline");
`endif

endmodule
`default_nettype wire

/* rtl/sensor_frame_crc_check_convert.sv */
`default_nettype none
// the result passes the frame queue, the multiply stage and the output register after the sixth frame byte is accepted
// throughput: one byte per cycle while the frame queue has room; at most one result per six bytes, queue of two frames
// the byte side stalls whenever the frame queue is full
// reset: synchronous, active high; clears position, crc, queue and valid flags
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_convert: sensor frame crc check and conversion
// Checks the two crc-8 words of a six-byte sensor frame and converts the
// temperature and humidity words to q8 units.
// ----------------------------------------------------------------------------
module sensor_frame_crc_check_convert
   import sfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [16:0] temperature_q8, [31:17] humidity_q8
   output logic             rsp_tuser    // [0] crc_error
);

   frame_rec_type     push_rec, pop_rec;
   logic              push, pop, q_not_full, q_not_empty;
   logic [TEMP_W-1:0] temp;
   logic [HUM_W-1:0]  hum;

   assign req_tready = q_not_full;

   // byte front end
   sfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid && q_not_full),
      .byte_data  (req_tdata),
      .byte_first (req_tuser),
      .rec_data   (push_rec),
      .rec_push   (push)
   );

   // frame queue
   sfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_rec),
      .not_full  (q_not_full),
      .pop       (pop),
      .pop_data  (pop_rec),
      .not_empty (q_not_empty)
   );

   // conversion back end
   sfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (q_not_empty),
      .rec_data  (pop_rec),
      .rec_pop   (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_temp  (temp),
      .out_hum   (hum),
      .out_bad   (rsp_tuser)
   );

   assign rsp_tdata = {hum, temp};

endmodule
`default_nettype wire

/* verif/tb_sensor_frame_crc_check_convert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_crc_check_convert: self-checking bench for the frame checker
// Streams six-byte sensor frames into the block, predicts every converted
// reading from its own crc and q8 arithmetic, and checks each output
// transaction field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sensor_frame_crc_check_convert;
   import sfc_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int LONG_HOLD    = 200;
   localparam int PHASE1_BYTES = 500;
   localparam int PHASE2_BYTES = 1000;
   localparam int TOTAL_BYTES  = 1376;
   localparam int END_WAIT     = 10;

   typedef struct packed {
      logic [7:0] value;
      logic       first;
   } frame_byte_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic [HUM_W-1:0]  hum;
      logic              crc_error;
   } reading_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tuser  = 1'b0;    // [0] frame_start
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [31:0] rsp_tdata;            // [16:0] temperature_q8, [31:17] humidity_q8
   wire         rsp_tuser;            // [0] crc_error

   // stimulus and expectation stores
   frame_byte_type frame_bytes_pending[$];
   reading_type    readings_due[$];

   // run control shared with the initial block
   bit idle_on   = 1'b1;
   int hold_left = 0;
   int send_gap  = 0;
   int recv_gap  = 0;
   int quiet     = 0;

   // bookkeeping
   int bytes_queued   = 0;
   int bytes_accepted = 0;
   int readings_seen  = 0;
   int crc_flagged    = 0;
   int fails          = 0;

   // predicted frame state
   logic [POS_W-1:0]  pos_now      = POS_T_HI;
   logic [7:0]        crc_now      = CRC_INIT;
   logic [WORD_W-1:0] temp_word    = '0;
   logic [WORD_W-1:0] hum_word     = '0;
   logic              temp_crc_bad = 1'b0;

   sensor_frame_crc_check_convert i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] value);
      logic [7:0] c;
      c = crc ^ value;
      repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      return c;
   endfunction

   // advance the predicted frame state by one accepted byte
   task automatic decode_frame_byte(input logic [7:0] value, input logic first);
      logic [POS_W-1:0]   pos;
      logic               bad;
      logic [TPROD_W-1:0] tprod;
      logic [HPROD_W-1:0] hprod;
      reading_type        r;
      pos = (first || pos_now > POS_H_CRC) ? POS_T_HI : pos_now;
      pos_now = pos + 1'b1;
      case (pos)
         POS_T_HI: begin
            crc_now   = crc8_next(CRC_INIT, value);
            temp_word = {value, 8'h00};
         end
         POS_T_LO: begin
            crc_now        = crc8_next(crc_now, value);
            temp_word[7:0] = value;
         end
         POS_T_CRC: begin
            temp_crc_bad = (crc_now != value);
            crc_now      = CRC_INIT;
         end
         POS_H_HI: begin
            crc_now  = crc8_next(CRC_INIT, value);
            hum_word = {value, 8'h00};
         end
         POS_H_LO: begin
            crc_now       = crc8_next(crc_now, value);
            hum_word[7:0] = value;
         end
         default: begin
            // sixth byte: final check and q8 conversion
            bad     = temp_crc_bad || (crc_now != value);
            crc_now = CRC_INIT;
            pos_now = POS_T_HI;
            tprod   = TPROD_W'(temp_word) * TPROD_W'(TEMP_SCALE);
            hprod   = HPROD_W'(hum_word) * HPROD_W'(HUM_SCALE);
            r.crc_error = bad;
            r.temp      = bad ? '0 : TEMP_W'(tprod >> 8) - TEMP_OFFSET;
            r.hum       = bad ? '0 : HUM_W'(hprod >> 8);
            readings_due.push_back(r);
            if (bad) crc_flagged++;
         end
      endcase
   endtask

   task automatic push_byte(input logic [7:0] value, input logic first);
      frame_byte_type fb;
      fb.value = value;
      fb.first = first;
      frame_bytes_pending.push_back(fb);
      bytes_queued++;
   endtask

   // queue a frame, optionally damaged at one byte and cut short
   task automatic push_frame(input logic [15:0] t, input logic [15:0] h, input logic first,
                             input int flip_at, input logic [7:0] flip, input int len);
      logic [7:0] fb [6];
      fb[0] = t[15:8];
      fb[1] = t[7:0];
      fb[2] = crc8_next(crc8_next(CRC_INIT, t[15:8]), t[7:0]);
      fb[3] = h[15:8];
      fb[4] = h[7:0];
      fb[5] = crc8_next(crc8_next(CRC_INIT, h[15:8]), h[7:0]);
      if (flip_at >= 0 && flip_at < 6) fb[flip_at] ^= flip;
      for (int i = 0; i < len; i++) push_byte(fb[i], first && (i == 0));
   endtask

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly clean frames, some damaged or cut short, some stray bytes
   task automatic push_random_chunk();
      int   kind;
      logic first;
      kind  = $urandom_range(0, 15);
      first = ($urandom_range(0, 7) != 0);
      if (kind < 11) begin
         push_frame(rand_word(), rand_word(), first, -1, 8'h00, 6);
      end else if (kind < 13) begin
         push_frame(rand_word(), rand_word(), first, $urandom_range(0, 5),
                    8'($urandom_range(1, 255)), 6);
      end else if (kind == 13) begin
         push_frame(rand_word(), rand_word(), first, -1, 8'h00, $urandom_range(1, 5));
      end else begin
         repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)),
                                                 $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic wait_drained();
      while (frame_bytes_pending.size() != 0 || bytes_accepted != bytes_queued ||
             readings_due.size() != 0) @(negedge clock);
   endtask

   // byte side driver
   always @(posedge clock) begin : byte_driver
      frame_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (frame_bytes_pending.size() != 0) begin
            nxt = frame_bytes_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.value;
            req_tuser  <= nxt.first;
            if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // reading side ready, with random stalls and the long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 14);
      end
   end

   // monitor: check readings, then predict from accepted bytes
   always @(posedge clock) begin : monitor
      reading_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            readings_seen++;
            if (readings_due.size() == 0) begin
               $error("reading with none expected: tdata %h tuser %b", rsp_tdata, rsp_tuser);
               fails++;
            end else begin
               want = readings_due.pop_front();
               if (rsp_tdata[16:0] !== want.temp) begin
                  $error("temperature_q8 expected %0d got %0d",
                         $signed(want.temp), $signed(rsp_tdata[16:0]));
                  fails++;
               end
               if (rsp_tdata[31:17] !== want.hum) begin
                  $error("humidity_q8 expected %0d got %0d", want.hum, rsp_tdata[31:17]);
                  fails++;
               end
               if (rsp_tuser !== want.crc_error) begin
                  $error("crc_error expected %0d got %0d", want.crc_error, rsp_tuser);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            decode_frame_byte(req_tdata, req_tuser);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet == QUIET_LIMIT) begin
            $display("timeout: %0d readings still expected", readings_due.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extreme words, continuation without frame start,
      // bad temperature crc, aborted frame, bad humidity crc
      push_frame(16'h0000, 16'h0000, 1'b1, -1, 8'h00, 6);
      push_frame(16'hFFFF, 16'hFFFF, 1'b0, -1, 8'h00, 6);
      push_frame(16'h6666, 16'h8000, 1'b1, 2, 8'h01, 6);
      push_frame(16'h1234, 16'h5678, 1'b1, -1, 8'h00, 2);
      push_frame(16'h8000, 16'h7FFF, 1'b1, 5, 8'h80, 6);

      // random with idling on both sides
      while (bytes_queued < PHASE1_BYTES) push_random_chunk();

      // sender pause until everything has drained
      wait_drained();

      // long receiver hold while clean frames and then random chunks keep coming
      hold_left = LONG_HOLD;
      repeat (25) push_frame(rand_word(), rand_word(), 1'b1, -1, 8'h00, 6);
      while (bytes_queued < PHASE2_BYTES) push_random_chunk();

      // last stretch without idling
      while (frame_bytes_pending.size() != 0) @(negedge clock);
      idle_on = 1'b0;
      while (bytes_queued < TOTAL_BYTES) push_random_chunk();

      wait_drained();
      repeat (END_WAIT) @(negedge clock);

      $display("covered %0d frame bytes and %0d readings, %0d of them flagged bad crc",
               bytes_accepted, readings_seen, crc_flagged);
      $display("incl. aborted and unmarked frames, stray bytes, a long output hold and a drain");
      if (fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sensor_frame_crc_check_convert.f */
rtl/sfc_pkg.sv
rtl/sfc_front.sv
rtl/sfc_queue.sv
rtl/sfc_back.sv
rtl/sensor_frame_crc_check_convert.sv
verif/tb_sensor_frame_crc_check_convert.sv
